// ===== rtl/pol_pkg.sv =====
// Shared types and codes for the positional ordered list block.
// Holds command and status codes, the cell control struct and the controller states.
// No dependencies.
package pol_pkg;

  localparam int DEFAULT_DEPTH      = 32;
  localparam int DEFAULT_DATA_WIDTH = 32;
  localparam int IDX_W              = 8;

  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_INS_AT    = 3'd2;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
  localparam logic [2:0] CMD_DEL_AT    = 3'd5;
  localparam logic [2:0] CMD_DUMP      = 3'd6;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_EMPTY    = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;
  localparam logic [1:0] STS_FULL     = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } pol_op_t;

  typedef struct packed {
    pol_op_t            op;
    logic [IDX_W-1:0]   k;
    logic [IDX_W-1:0]   last;
  } pol_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DUMP
  } pol_state_t;

endpackage

// ===== rtl/positional_ordered_list.sv =====
// Top level of the positional ordered list: controller plus a row of pol_cell.
// Uses pol_pkg for codes, cell control and states.
//
// Usage: an item (in_cmd, in_value, in_position) is taken when start is high
// and busy is low. Edits (inserts and deletes at front, back or a 1-based
// position) give one result; a dump gives one result per stored element from
// front to back, or a single empty result when the list holds nothing.
// Each result is shown for one cycle with out_valid high; out_last marks the
// final result of an item and out_length gives the element count after it.
// Timing: an edit is taken, then executed, and its result appears in the
// cycle after execution; busy drops as the result is shown, so the next
// item can be taken then. A dump holds busy until its last element is shown
// and streams one element a cycle, set by the rotation of
// the cell chain, which brings each element to the head cell in turn.
// Reset clears the controller and the count; the list is then empty.
// The receiver cannot stall; results are never held back.
module positional_ordered_list #(
  parameter int DEPTH      = pol_pkg::DEFAULT_DEPTH,
  parameter int DATA_WIDTH = pol_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic signed [31:0] in_value,
  input  logic [5:0]  in_position,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_element,
  output logic        out_last,
  output logic [5:0]  out_length
);
  import pol_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

  pol_state_t state_r, state_nxt;
  logic [2:0]            cmd_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [5:0]            pos_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         dcnt_r, dcnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_element_r, out_element_nxt;
  logic        out_last_r, out_last_nxt;
  logic [5:0]  out_length_r;

  pol_ctl_t              ctl;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH+31:0] value_ext;
  logic [DATA_WIDTH+31:0] head_ext;
  logic [CMPW-1:0]       pos_x, n_x, k_x;
  logic                  accept, full, empty;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign value_ext = {{DATA_WIDTH{in_value[31]}}, in_value};
  assign head_ext  = {32'b0, cell_data[0]};
  assign pos_x     = CMPW'(pos_r);
  assign n_x       = CMPW'(count_r);
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    dcnt_nxt        = dcnt_r;
    k_x             = '0;
    ctl.op          = OP_HOLD;
    ctl.k           = '0;
    ctl.last        = IDX_W'(n_x - CMPW'(1));
    out_valid_nxt   = 1'b0;
    out_status_nxt  = STS_OK;
    out_element_nxt = '0;
    out_last_nxt    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        case (cmd_r)
          CMD_INS_FRONT, CMD_INS_BACK: begin
            if (full) begin
              out_status_nxt = STS_FULL;
            end else begin
              k_x       = (cmd_r == CMD_INS_FRONT) ? '0 : n_x;
              ctl.op    = OP_INS;
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_INS_AT: begin
            if (pos_x == '0 || pos_x > n_x + CMPW'(1)) begin
              out_status_nxt = STS_NOTFOUND;
            end else if (full) begin
              out_status_nxt = STS_FULL;
            end else begin
              k_x       = pos_x - CMPW'(1);
              ctl.op    = OP_INS;
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_DEL_FRONT, CMD_DEL_BACK: begin
            if (empty) begin
              out_status_nxt = STS_EMPTY;
            end else begin
              k_x       = (cmd_r == CMD_DEL_FRONT) ? '0 : n_x - CMPW'(1);
              ctl.op    = OP_DEL;
              count_nxt = count_r - CW'(1);
            end
          end
          CMD_DEL_AT: begin
            if (empty) begin
              out_status_nxt = STS_EMPTY;
            end else if (pos_x == '0 || pos_x > n_x) begin
              out_status_nxt = STS_NOTFOUND;
            end else begin
              k_x       = pos_x - CMPW'(1);
              ctl.op    = OP_DEL;
              count_nxt = count_r - CW'(1);
            end
          end
          CMD_DUMP: begin
            if (empty) begin
              out_status_nxt = STS_EMPTY;
            end else begin
              out_valid_nxt = 1'b0;
              dcnt_nxt      = '0;
              state_nxt     = ST_DUMP;
            end
          end
          default: out_status_nxt = STS_OK;
        endcase
        ctl.k = IDX_W'(k_x);
      end
      ST_DUMP: begin
        out_valid_nxt   = 1'b1;
        out_element_nxt = head_ext[31:0];
        out_last_nxt    = (dcnt_r == count_r - CW'(1));
        ctl.op          = OP_ROT;
        dcnt_nxt        = dcnt_r + CW'(1);
        if (out_last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      value_r <= value_ext[DATA_WIDTH-1:0];
      pos_r   <= in_position;
    end
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
    out_length_r  <= 6'(count_nxt);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    pol_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .value_i(value_r),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (cell_data[0]),
      .data_o (cell_data[i])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;
  assign out_length  = out_length_r;

endmodule

// ===== rtl/pol_cell.sv =====
// One storage cell of the list chain (uses pol_pkg): holds one element.
// Shifts neighbors on insert, delete, rotate; loads value_i or head_i too.
module pol_cell #(
  parameter int DATA_WIDTH = pol_pkg::DEFAULT_DATA_WIDTH,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  pol_pkg::pol_ctl_t     ctl,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] head_i,
  output logic [DATA_WIDTH-1:0] data_o
);
  import pol_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_INS: begin
        if (MY_IDX == ctl.k) begin
          data_nxt = value_i;
        end else if (MY_IDX > ctl.k) begin
          data_nxt = left_i;
        end
      end
      OP_DEL: begin
        if (MY_IDX >= ctl.k) begin
          data_nxt = right_i;
        end
      end
      OP_ROT: begin
        if (MY_IDX == ctl.last) begin
          data_nxt = head_i;
        end else if (MY_IDX < ctl.last) begin
          data_nxt = right_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// ===== rtl/pol_checker.sv =====
// Port-level checks for positional_ordered_list, attached by a bind statement.
// Uses pol_pkg status codes.
module pol_checker #(
  parameter int DEPTH = pol_pkg::DEFAULT_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_element,
  input logic        out_last,
  input logic [5:0]  out_length
);
  import pol_pkg::*;

  // A dump streams without gaps until its last item.
  a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("dump stream broke before its last item");

  a_taken_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_EMPTY |-> out_length == 6'd0)
    else $error("empty status with nonzero length");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_FULL |-> out_length == 6'(DEPTH))
    else $error("full status while list not at capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |-> out_element == 32'd0 && out_last)
    else $error("error result carries data or is not last");

endmodule

bind positional_ordered_list pol_checker #(.DEPTH(DEPTH)) u_pol_checker (.*);

// ===== tb/tb_positional_ordered_list.sv =====
`timescale 1ns / 1ps
// Testbench for positional_ordered_list: directed and random list commands with a scoreboard.
// Depends on pol_pkg and the positional_ordered_list RTL; needs no files or arguments.
module tb_positional_ordered_list;
  import pol_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int RANDOM_ITEMS = 380;
  localparam int STALL_LIMIT = 2000;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct {
    logic [1:0] status;
    logic signed [31:0] element;
    logic last;
    logic [5:0] length;
  } list_result_t;

  class list_tracker;
    logic signed [31:0] shadow_list[$];
    list_result_t due_results[$];
    int failures;
    int reported;

    function void push_result(logic [1:0] status, logic signed [31:0] element, logic last);
      list_result_t r;
      r.status = status;
      r.element = element;
      r.last = last;
      r.length = 6'(shadow_list.size());
      due_results.push_back(r);
    endfunction

    function void note_command(logic [2:0] cmd, logic signed [31:0] value, logic [5:0] pos);
      int count;
      int p;
      logic [1:0] status;
      count = shadow_list.size();
      p = int'(pos);
      status = STS_OK;
      case (cmd)
        CMD_INS_FRONT, CMD_INS_BACK: begin
          if (count >= LIST_DEPTH) status = STS_FULL;
          else if (cmd == CMD_INS_FRONT) shadow_list.push_front(value);
          else shadow_list.push_back(value);
        end
        CMD_INS_AT: begin
          if (p < 1 || p > count + 1) status = STS_NOTFOUND;
          else if (count >= LIST_DEPTH) status = STS_FULL;
          else shadow_list.insert(p - 1, value);
        end
        CMD_DEL_FRONT, CMD_DEL_BACK: begin
          if (count == 0) status = STS_EMPTY;
          else if (cmd == CMD_DEL_FRONT) void'(shadow_list.pop_front());
          else void'(shadow_list.pop_back());
        end
        CMD_DEL_AT: begin
          if (count == 0) status = STS_EMPTY;
          else if (p < 1 || p > count) status = STS_NOTFOUND;
          else shadow_list.delete(p - 1);
        end
        CMD_DUMP: begin
          if (count == 0) begin
            push_result(STS_EMPTY, 0, 1'b1);
          end else begin
            for (int i = 0; i < count; i++) push_result(STS_OK, shadow_list[i], i == count - 1);
          end
          return;
        end
        default: ;
      endcase
      push_result(status, 0, 1'b1);
    endfunction

    function void check_result(logic [1:0] status, logic signed [31:0] element, logic last,
                               logic [5:0] length);
      list_result_t e;
      if (due_results.size() == 0) begin
        failures++;
        if (reported < 10)
          $display("unexpected result: status %0d element %0d last %0d length %0d",
                   status, element, last, length);
        reported++;
        return;
      end
      e = due_results.pop_front();
      if (e.status !== status || e.element !== element || e.last !== last ||
          e.length !== length) begin
        failures++;
        if (reported < 10)
          $display({"mismatch: expected status %0d element %0d last %0d length %0d, ",
                    "got %0d %0d %0d %0d"},
                   e.status, e.element, e.last, e.length, status, element, last, length);
        reported++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_cmd;
  logic signed [31:0] in_value;
  logic [5:0] in_position;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [31:0] out_element;
  logic out_last;
  logic [5:0] out_length;

  list_tracker tracker;
  int idle_cycles;

  positional_ordered_list u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_element(out_element),
    .out_last(out_last),
    .out_length(out_length)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_result(out_status, out_element, out_last, out_length);
      if (start && !busy) tracker.note_command(in_cmd, in_value, in_position);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [2:0] cmd, input logic signed [31:0] value,
                           input logic [5:0] pos);
    start <= 1'b1;
    in_cmd <= cmd;
    in_value <= value;
    in_position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.due_results.size() > 0) @(posedge clk);
  endtask

  task automatic pick_item(input int ins_pct, output logic [2:0] cmd,
                           output logic signed [31:0] value, output logic [5:0] pos);
    int r;
    int len;
    r = $urandom_range(0, 99);
    len = tracker.shadow_list.size();
    if (r < ins_pct) cmd = 3'($urandom_range(CMD_INS_FRONT, CMD_INS_AT));
    else if (r < 93) cmd = 3'($urandom_range(CMD_DEL_FRONT, CMD_DEL_AT));
    else if (r < 99) cmd = CMD_DUMP;
    else cmd = CMD_UNUSED;
    case ($urandom_range(0, 7))
      0: value = 32'sh7fffffff;
      1: value = 32'sh80000000;
      2: value = 0;
      3: value = -1;
      default: value = $urandom;
    endcase
    if ($urandom_range(0, 9) == 0) pos = 6'($urandom_range(0, 63));
    else pos = 6'($urandom_range(1, len + 1));
  endtask

  initial begin
    logic [2:0] cmd;
    logic signed [31:0] value;
    logic [5:0] pos;
    int n;
    int burst;
    int gap;
    int ins_pct;
    bit drained_mid;

    tracker = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_INS_FRONT;
    in_value = 0;
    in_position = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_DUMP, 0, 0);
    send_item(CMD_DEL_FRONT, 0, 0);
    send_item(CMD_DEL_BACK, 0, 0);
    send_item(CMD_DEL_AT, 0, 1);
    send_item(CMD_INS_AT, 32'sh12345678, 0);
    send_item(CMD_INS_AT, 32'sh12345678, 2);
    send_item(CMD_INS_AT, 32'sh7fffffff, 1);
    send_item(CMD_INS_BACK, 32'sh80000000, 0);
    send_item(CMD_INS_FRONT, -1, 0);
    send_item(CMD_INS_AT, 0, 4);
    send_item(CMD_INS_AT, 32'sh5a5a5a5a, 2);
    send_item(CMD_DEL_AT, 0, 0);
    send_item(CMD_DEL_AT, 0, 6);
    send_item(CMD_DEL_AT, 0, 63);
    send_item(CMD_INS_AT, 32'sha5a5a5a5, 63);
    send_item(CMD_DEL_AT, 0, 3);
    send_item(CMD_DUMP, 0, 0);
    send_item(CMD_UNUSED, $urandom, 6'($urandom_range(0, 63)));
    send_item(CMD_DEL_FRONT, 0, 0);
    send_item(CMD_DEL_BACK, 0, 0);
    send_item(CMD_DUMP, 0, 0);
    drain_results();

    n = 0;
    drained_mid = 1'b0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      ins_pct = ((n / 60) % 2 == 0) ? 78 : 15;
      repeat (burst) begin
        pick_item(ins_pct, cmd, value, pos);
        send_item(cmd, value, pos);
        n++;
      end
      if (!drained_mid && n >= RANDOM_ITEMS / 2) begin
        drained_mid = 1'b1;
        drain_results();
      end else if ((n / 50) % 3 != 2 && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (tracker.failures == 0 && tracker.due_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pol_pkg.sv
rtl/pol_cell.sv
rtl/positional_ordered_list.sv
rtl/pol_checker.sv
tb/tb_positional_ordered_list.sv
